/* hw/rtl/ilsr_pkg.sv */
// ilsr_pkg: step tables, codes and widths for the light sensor reader
// no dependencies; imported by i2c_light_sensor_reader_unit and ilsr_checker
`default_nettype none

package ilsr_pkg;

   localparam int STEP_W   = 5;
   localparam int NUM_STEPS = 20;
   localparam int WAIT_W   = 24;
   localparam int REQ_W    = 8;
   localparam int RSP_W    = 24;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 24;

   typedef logic [STEP_W-1:0] step_type;
   typedef logic [2:0]        kind_type;
   typedef logic [1:0]        src_type;

   // step kinds
   localparam kind_type KIND_IDLE  = 3'd0;
   localparam kind_type KIND_WAIT  = 3'd1;
   localparam kind_type KIND_START = 3'd2;
   localparam kind_type KIND_SEND  = 3'd3;
   localparam kind_type KIND_READ  = 3'd4;
   localparam kind_type KIND_STOP  = 3'd5;

   // byte sources for send steps
   localparam src_type SRC_ADDR_W = 2'd0;
   localparam src_type SRC_POWER  = 2'd1;
   localparam src_type SRC_MODE   = 2'd2;
   localparam src_type SRC_ADDR_R = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DEVICE_ADDRESS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE_COMMAND    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STARTUP_WAIT    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CONVERSION_WAIT = 2'd3;

   localparam logic [6:0]        RST_DEVICE_ADDRESS  = 7'd35;
   localparam logic [7:0]        RST_MODE_COMMAND    = 8'd16;
   localparam logic [WAIT_W-1:0] RST_STARTUP_WAIT    = 24'd200000;
   localparam logic [WAIT_W-1:0] RST_CONVERSION_WAIT = 24'd1500000;

   localparam logic [7:0] POWER_ON_CMD = 8'h01;
   localparam step_type   STEP_IDLE  = 5'd0;
   localparam step_type   STEP_BEGIN = 5'd1;
   localparam step_type   STEP_LAST  = 5'd19;

   function automatic kind_type step_kind(input step_type s);
      kind_type k;
      unique case (s)
         5'd1, 5'd14:                     k = KIND_WAIT;
         5'd2, 5'd6, 5'd10, 5'd15:        k = KIND_START;
         5'd3, 5'd4, 5'd7, 5'd8,
         5'd11, 5'd12, 5'd16:             k = KIND_SEND;
         5'd17, 5'd18:                    k = KIND_READ;
         5'd5, 5'd9, 5'd13, 5'd19:        k = KIND_STOP;
         default:                         k = KIND_IDLE;
      endcase
      return k;
   endfunction

   // send: ack number, read: master ack, wait: conversion wait
   function automatic logic [2:0] step_arg(input step_type s);
      logic [2:0] a;
      unique case (s)
         5'd3:                a = 3'd1;
         5'd4:                a = 3'd2;
         5'd7:                a = 3'd3;
         5'd8:                a = 3'd4;
         5'd11:               a = 3'd5;
         5'd12:               a = 3'd6;
         5'd16:               a = 3'd7;
         5'd14, 5'd17:        a = 3'd1;
         default:             a = 3'd0;
      endcase
      return a;
   endfunction

   function automatic src_type step_src(input step_type s);
      src_type r;
      unique case (s)
         5'd4, 5'd8: r = SRC_POWER;
         5'd12:      r = SRC_MODE;
         5'd16:      r = SRC_ADDR_R;
         default:    r = SRC_ADDR_W;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/i2c_light_sensor_reader_unit.sv */
// i2c_light_sensor_reader_unit: tick-driven i2c master reading a light sensor
// depends on ilsr_pkg
`default_nettype none

// Usage:
//   req_ channel carries one timing tick per word: begin request and the
//   sampled sda level. Each accepted word yields exactly one rsp_ word with
//   the scl/sda drive for that tick, busy, a done pulse, the latched status
//   (0 ok, 1..7 = which acknowledge failed) and the latched 16-bit reading.
//   csr_ port writes device address, mode command and the two wait counts
//   (in ticks); write only while no sequence runs.
//   A result word is registered and appears in the cycle after its tick word is taken.
//   Throughput: one tick word per cycle unless stalled; the sequencer state
//   register is updated once per accepted word by a single next-state pass.
//   When the receiver stalls, the result word is held in the output
//   register and req_tready drops until it is taken; no word is lost.
//   Reset clears the sequencer to idle, the latched result to zero and the
//   registers to address 35, mode 16, startup wait 200000, conversion wait
//   1500000 ticks.
module i2c_light_sensor_reader_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output      logic                              req_tready,
   input  wire logic [ilsr_pkg::REQ_W-1:0]        req_tdata,  // begin_req, sda_in, zero pad
   output      logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   output      logic [ilsr_pkg::RSP_W-1:0]        rsp_tdata,  // scl_level, sda_level,
                                                              // sda_enable, busy_res, done_res,
                                                              // status[2:0], reading[15:0]
   input  wire logic                              csr_we,
   input  wire logic [ilsr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [ilsr_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import ilsr_pkg::*;

   // configuration
   logic [6:0]        dev_addr_ff;
   logic [7:0]        mode_cmd_ff;
   logic [WAIT_W-1:0] startup_wait_ff;
   logic [WAIT_W-1:0] conv_wait_ff;

   // sequencer state
   step_type          step_ff, step_in;
   logic [1:0]        phase_ff, phase_in;
   logic [3:0]        bit_cnt_ff, bit_cnt_in;
   logic [7:0]        shift_ff, shift_in;
   logic [WAIT_W-1:0] wait_ff, wait_in;
   logic [7:0]        high_ff, high_in;
   logic [15:0]       reading_ff, reading_in;
   logic [2:0]        status_ff, status_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]  rsp_data_ff, rsp_data_in;

   logic              req_take;
   logic              begin_req, sda_in;
   logic              scl_o, sda_o, en_o, done_o;
   logic              go;
   step_type          target;
   kind_type          cur_kind;
   logic [2:0]        cur_arg;
   logic [WAIT_W-1:0] limit;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_take   = req_tvalid && req_tready;
   assign begin_req  = req_tdata[0];
   assign sda_in     = req_tdata[1];
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      step_in    = step_ff;
      phase_in   = phase_ff;
      bit_cnt_in = bit_cnt_ff;
      shift_in   = shift_ff;
      wait_in    = wait_ff;
      high_in    = high_ff;
      reading_in = reading_ff;
      status_in  = status_ff;
      scl_o      = 1'b0;
      sda_o      = 1'b1;
      en_o       = 1'b1;
      done_o     = 1'b0;
      go         = 1'b0;
      target     = STEP_IDLE;
      cur_kind   = step_kind(step_ff);
      cur_arg    = step_arg(step_ff);
      limit      = cur_arg[0] ? conv_wait_ff : startup_wait_ff;

      unique case (cur_kind)
         KIND_WAIT: begin
            // a zero or one count still costs one tick
            if ({1'b0, wait_ff} + 25'd1 >= {1'b0, limit}) begin
               go     = 1'b1;
               target = step_ff + 5'd1;
            end else begin
               wait_in = wait_ff + 24'd1;
            end
         end
         KIND_START: begin
            scl_o    = (phase_ff == 2'd0);
            sda_o    = (phase_ff == 2'd0);
            phase_in = phase_ff + 2'd1;
            if (phase_ff == 2'd2) begin
               go     = 1'b1;
               target = step_ff + 5'd1;
            end
         end
         KIND_SEND: begin
            scl_o = (phase_ff == 2'd1);
            if (bit_cnt_ff < 4'd8) begin
               sda_o    = shift_ff[7];
               phase_in = phase_ff + 2'd1;
               if (phase_ff == 2'd2) begin
                  phase_in   = 2'd0;
                  shift_in   = {shift_ff[6:0], 1'b0};
                  bit_cnt_in = bit_cnt_ff + 4'd1;
               end
            end else begin
               en_o = 1'b0;
               if (phase_ff == 2'd1 && sda_in) begin
                  // missing ack: abort without stop
                  status_in  = cur_arg;
                  reading_in = 16'd0;
                  done_o     = 1'b1;
                  go         = 1'b1;
                  target     = STEP_IDLE;
               end else begin
                  phase_in = phase_ff + 2'd1;
                  if (phase_ff == 2'd2) begin
                     go     = 1'b1;
                     target = step_ff + 5'd1;
                  end
               end
            end
         end
         KIND_READ: begin
            if (bit_cnt_ff < 4'd8) begin
               en_o  = 1'b0;
               scl_o = (phase_ff == 2'd0);
               if (phase_ff == 2'd0) begin
                  shift_in = {shift_ff[6:0], sda_in};
                  phase_in = 2'd1;
               end else begin
                  phase_in   = 2'd0;
                  bit_cnt_in = bit_cnt_ff + 4'd1;
               end
            end else begin
               sda_o    = !cur_arg[0];
               scl_o    = (phase_ff == 2'd1);
               phase_in = phase_ff + 2'd1;
               if (phase_ff == 2'd2) begin
                  if (cur_arg[0]) begin
                     high_in = shift_ff;
                  end
                  go     = 1'b1;
                  target = step_ff + 5'd1;
               end
            end
         end
         KIND_STOP: begin
            scl_o    = (phase_ff == 2'd1) || (phase_ff == 2'd2);
            sda_o    = phase_ff[1];
            phase_in = phase_ff + 2'd1;
            if (phase_ff == 2'd3) begin
               go = 1'b1;
               if (step_ff == STEP_LAST) begin
                  reading_in = {high_ff, shift_ff};
                  status_in  = 3'd0;
                  done_o     = 1'b1;
                  target     = STEP_IDLE;
               end else begin
                  target = step_ff + 5'd1;
               end
            end
         end
         default: begin
            // idle, also recovers from an unused step value
            go     = 1'b1;
            target = begin_req ? STEP_BEGIN : STEP_IDLE;
         end
      endcase

      if (go) begin
         step_in    = target;
         phase_in   = 2'd0;
         bit_cnt_in = 4'd0;
         wait_in    = '0;
         if (step_kind(target) == KIND_SEND) begin
            unique case (step_src(target))
               SRC_ADDR_W: shift_in = {dev_addr_ff, 1'b0};
               SRC_POWER:  shift_in = POWER_ON_CMD;
               SRC_MODE:   shift_in = mode_cmd_ff;
               SRC_ADDR_R: shift_in = {dev_addr_ff, 1'b1};
               default:    shift_in = {dev_addr_ff, 1'b0};
            endcase
         end else if (step_kind(target) == KIND_READ) begin
            shift_in = 8'd0;
         end
      end

      rsp_data_in  = {reading_in, status_in, done_o, (step_in != STEP_IDLE), en_o,
                      sda_o, scl_o};
      rsp_valid_in = req_take || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff     <= RST_DEVICE_ADDRESS;
         mode_cmd_ff     <= RST_MODE_COMMAND;
         startup_wait_ff <= RST_STARTUP_WAIT;
         conv_wait_ff    <= RST_CONVERSION_WAIT;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DEVICE_ADDRESS:  dev_addr_ff     <= csr_wdata[6:0];
            CSR_MODE_COMMAND:    mode_cmd_ff     <= csr_wdata[7:0];
            CSR_STARTUP_WAIT:    startup_wait_ff <= csr_wdata[WAIT_W-1:0];
            CSR_CONVERSION_WAIT: conv_wait_ff    <= csr_wdata[WAIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_IDLE;
         phase_ff     <= 2'd0;
         bit_cnt_ff   <= 4'd0;
         shift_ff     <= 8'd0;
         wait_ff      <= '0;
         high_ff      <= 8'd0;
         reading_ff   <= 16'd0;
         status_ff    <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_take) begin
            step_ff    <= step_in;
            phase_ff   <= phase_in;
            bit_cnt_ff <= bit_cnt_in;
            shift_ff   <= shift_in;
            wait_ff    <= wait_in;
            high_ff    <= high_in;
            reading_ff <= reading_in;
            status_ff  <= status_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/ilsr_checker.sv */
// ilsr_checker: port-level checks for i2c_light_sensor_reader_unit
// depends on ilsr_pkg; bound into i2c_light_sensor_reader_unit below
`default_nettype none

module ilsr_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_tvalid,
   input wire logic                       req_tready,
   input wire logic                       rsp_tvalid,
   input wire logic                       rsp_tready,
   input wire logic [ilsr_pkg::RSP_W-1:0] rsp_tdata
);
   import ilsr_pkg::*;

   // result register empties on reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result word valid right after reset");

   // every tick word taken gives a result word next cycle
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted tick produced no result word");

   // input side never blocked while result register is free
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty result register");

   // done coincides with return to idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[4] |-> !rsp_tdata[3])
      else $error("done pulse while still busy");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result word changed");

endmodule

bind i2c_light_sensor_reader_unit ilsr_checker u_ilsr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

/* bench/tb_i2c_light_sensor_reader_unit.sv */
// tb_i2c_light_sensor_reader_unit: self-checking bench for the light sensor reader
// drives timing tick words, predicts every result word, checks them in order
// depends on ilsr_pkg and i2c_light_sensor_reader_unit
`timescale 1ns / 1ps

module tb_i2c_light_sensor_reader_unit;
   import ilsr_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int MAX_REPORTS    = 10;

   // sequencer steps, in the order the sequence walks them
   typedef enum logic [4:0] {
      S_IDLE, S_WAIT_START,
      S_START_PWR1, S_ADDR_PWR1, S_CMD_PWR1, S_STOP_PWR1,
      S_START_PWR2, S_ADDR_PWR2, S_CMD_PWR2, S_STOP_PWR2,
      S_START_MODE, S_ADDR_MODE, S_CMD_MODE, S_STOP_MODE,
      S_WAIT_CONV,
      S_START_READ, S_ADDR_READ, S_READ_HIGH, S_READ_LOW, S_STOP_READ
   } seq_step_type;

   typedef enum logic [2:0] {
      TK_IDLE, TK_WAIT, TK_START, TK_SEND, TK_READ, TK_STOP
   } tick_kind_type;

   // result word, scl_level in bit 0
   typedef struct packed {
      logic [15:0] reading;
      logic [2:0]  status;
      logic        done;
      logic        busy;
      logic        sda_en;
      logic        sda;
      logic        scl;
   } tick_word_type;

   class reader_scoreboard;
      logic [6:0]  dev_addr;
      logic [7:0]  mode_cmd;
      logic [23:0] start_wait;
      logic [23:0] conv_wait;

      seq_step_type step;
      logic [3:0]  phase;
      logic [3:0]  bits_done;
      logic [7:0]  shreg;
      logic [23:0] wait_cnt;
      logic [7:0]  hi_byte;
      logic [15:0] reading;
      logic [2:0]  status;

      tick_word_type expected_words[$];
      int          mismatches;

      function new();
         dev_addr   = RST_DEVICE_ADDRESS;
         mode_cmd   = RST_MODE_COMMAND;
         start_wait = RST_STARTUP_WAIT;
         conv_wait  = RST_CONVERSION_WAIT;
         step       = S_IDLE;
         phase      = '0;
         bits_done  = '0;
         shreg      = '0;
         wait_cnt   = '0;
         hi_byte    = '0;
         reading    = '0;
         status     = '0;
         mismatches = 0;
      endfunction

      function tick_kind_type kind_of(seq_step_type s);
         case (s)
            S_WAIT_START, S_WAIT_CONV:                       return TK_WAIT;
            S_START_PWR1, S_START_PWR2, S_START_MODE,
            S_START_READ:                                    return TK_START;
            S_ADDR_PWR1, S_CMD_PWR1, S_ADDR_PWR2, S_CMD_PWR2,
            S_ADDR_MODE, S_CMD_MODE, S_ADDR_READ:            return TK_SEND;
            S_READ_HIGH, S_READ_LOW:                         return TK_READ;
            S_STOP_PWR1, S_STOP_PWR2, S_STOP_MODE,
            S_STOP_READ:                                     return TK_STOP;
            default:                                         return TK_IDLE;
         endcase
      endfunction

      // which acknowledge a send step checks, counted from one
      function logic [2:0] ack_num(seq_step_type s);
         case (s)
            S_ADDR_PWR1: return 3'd1;
            S_CMD_PWR1:  return 3'd2;
            S_ADDR_PWR2: return 3'd3;
            S_CMD_PWR2:  return 3'd4;
            S_ADDR_MODE: return 3'd5;
            S_CMD_MODE:  return 3'd6;
            S_ADDR_READ: return 3'd7;
            default:     return 3'd0;
         endcase
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_DEVICE_ADDRESS:  dev_addr   = val[6:0];
            CSR_MODE_COMMAND:    mode_cmd   = val[7:0];
            CSR_STARTUP_WAIT:    start_wait = val[23:0];
            CSR_CONVERSION_WAIT: conv_wait  = val[23:0];
            default: ;
         endcase
      endfunction

      function void enter(int nxt);
         if (nxt > int'(S_STOP_READ))
            step = S_IDLE;
         else
            step = seq_step_type'(nxt);
         phase     = '0;
         bits_done = '0;
         wait_cnt  = '0;
         if (kind_of(step) == TK_SEND) begin
            case (step)
               S_CMD_PWR1, S_CMD_PWR2: shreg = POWER_ON_CMD;
               S_CMD_MODE:             shreg = mode_cmd;
               S_ADDR_READ:            shreg = {dev_addr, 1'b1};
               default:                shreg = {dev_addr, 1'b0};
            endcase
         end else if (kind_of(step) == TK_READ) begin
            shreg = '0;
         end
      endfunction

      // nonzero when the next tick samples the sensor's acknowledge
      function logic [2:0] ack_under_test();
         if (kind_of(step) == TK_SEND && bits_done == 4'd8 && phase == 4'd1)
            return ack_num(step);
         return 3'd0;
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      function void note_tick(bit start_req, bit sda_line);
         tick_word_type w;
         logic [23:0] limit;
         w = '0;
         w.sda = 1'b1;
         w.sda_en = 1'b1;
         case (kind_of(step))
            TK_WAIT: begin
               limit = (step == S_WAIT_CONV) ? conv_wait : start_wait;
               if (int'(wait_cnt) + 1 >= int'(limit))
                  enter(int'(step) + 1);
               else
                  wait_cnt = wait_cnt + 24'd1;
            end
            TK_START: begin
               w.scl = (phase == 4'd0);
               w.sda = (phase == 4'd0);
               phase = phase + 4'd1;
               if (phase >= 4'd3) enter(int'(step) + 1);
            end
            TK_SEND: begin
               if (bits_done < 4'd8) begin
                  w.sda = shreg[7];
                  w.scl = (phase == 4'd1);
                  phase = phase + 4'd1;
                  if (phase >= 4'd3) begin
                     phase = '0;
                     shreg = {shreg[6:0], 1'b0};
                     bits_done = bits_done + 4'd1;
                  end
               end else begin
                  w.sda_en = 1'b0;
                  w.scl = (phase == 4'd1);
                  if (phase == 4'd1 && sda_line) begin
                     // missing acknowledge: abort without a stop
                     status  = ack_num(step);
                     reading = '0;
                     w.done  = 1'b1;
                     enter(int'(S_IDLE));
                  end else begin
                     phase = phase + 4'd1;
                     if (phase >= 4'd3) enter(int'(step) + 1);
                  end
               end
            end
            TK_READ: begin
               if (bits_done < 4'd8) begin
                  w.sda_en = 1'b0;
                  w.scl = (phase == 4'd0);
                  if (phase == 4'd0) begin
                     shreg = {shreg[6:0], sda_line};
                     phase = 4'd1;
                  end else begin
                     phase = '0;
                     bits_done = bits_done + 4'd1;
                  end
               end else begin
                  // first byte acknowledged by the master, second one not
                  w.sda = (step == S_READ_HIGH) ? 1'b0 : 1'b1;
                  w.scl = (phase == 4'd1);
                  phase = phase + 4'd1;
                  if (phase >= 4'd3) begin
                     if (step == S_READ_HIGH) hi_byte = shreg;
                     enter(int'(step) + 1);
                  end
               end
            end
            TK_STOP: begin
               w.scl = (phase == 4'd1 || phase == 4'd2);
               w.sda = (phase >= 4'd2);
               phase = phase + 4'd1;
               if (phase >= 4'd4) begin
                  if (step == S_STOP_READ) begin
                     reading = {hi_byte, shreg};
                     status  = '0;
                     w.done  = 1'b1;
                     enter(int'(S_IDLE));
                  end else begin
                     enter(int'(step) + 1);
                  end
               end
            end
            default: begin
               if (start_req) enter(int'(S_WAIT_START));
            end
         endcase
         w.busy    = (step != S_IDLE);
         w.status  = status;
         w.reading = reading;
         expected_words.push_back(w);
      endfunction

      function void check_word(tick_word_type got);
         tick_word_type want;
         if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: result word with nothing expected: %h", $realtime, got);
            return;
         end
         want = expected_words.pop_front();
         if (got.scl !== want.scl || got.sda !== want.sda || got.sda_en !== want.sda_en ||
             got.busy !== want.busy || got.done !== want.done ||
             got.status !== want.status || got.reading !== want.reading) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: mismatch exp scl=%b sda=%b en=%b busy=%b done=%b st=%0d rd=%h",
                        $realtime, want.scl, want.sda, want.sda_en, want.busy, want.done,
                        want.status, want.reading,
                        "\n          got scl=%b sda=%b en=%b busy=%b done=%b st=%0d rd=%h",
                        got.scl, got.sda, got.sda_en, got.busy, got.done,
                        got.status, got.reading);
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata = '0;   // begin_req, sda_in, zero pad
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_W-1:0]      rsp_tdata;        // scl_level, sda_level, sda_enable, busy_res,
                                            // done_res, status[2:0], reading[15:0]
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   reader_scoreboard board;
   bit          allow_begin;
   logic [2:0]  fail_plan;
   logic [9:0]  stall_ctr = '0;
   int          quiet_cycles = 0;

   i2c_light_sensor_reader_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // receiver: checks result words, stalls in changing patterns
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_word(rsp_tdata);
      stall_ctr <= stall_ctr + 10'd1;
      case (stall_ctr[7:6])
         2'd0:    rsp_tready <= 1'b1;
         2'd1:    rsp_tready <= ($urandom_range(0, 9) < 7);
         2'd2:    rsp_tready <= (stall_ctr % 3 == 0);
         default: rsp_tready <= ($urandom_range(0, 9) < 3);
      endcase
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles = quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   task automatic send_tick(input bit start_req, input bit sda_line);
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_W-2){1'b0}}, sda_line, start_req};
      do @(posedge clock); while (!req_tready);
      board.note_tick(start_req, sda_line);
   endtask

   task automatic idle_gap(input int cycles);
      req_tvalid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   // mostly well-formed acks; a planned failure or rare noise aborts the run
   task automatic pick_tick(output bit start_req, output bit sda_line);
      logic [2:0] ack;
      if (board.step == S_IDLE) begin
         start_req = allow_begin && ($urandom_range(0, 3) == 0);
         sda_line  = 1'($urandom_range(0, 1));
         if (start_req)
            fail_plan = ($urandom_range(0, 1) == 0) ? 3'd0 : 3'($urandom_range(1, 7));
      end else begin
         start_req = ($urandom_range(0, 7) == 0);
         ack = board.ack_under_test();
         if (ack != 3'd0)
            sda_line = (ack == fail_plan) || ($urandom_range(0, 39) == 0);
         else
            sda_line = 1'($urandom_range(0, 1));
      end
   endtask

   task automatic run_ticks(input int count);
      int sent;
      int burst;
      int pick;
      bit b;
      bit s;
      sent = 0;
      while (sent < count) begin
         burst = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
         for (int i = 0; i < burst && sent < count; i++) begin
            pick_tick(b, s);
            send_tick(b, s);
            sent++;
         end
         pick = $urandom_range(0, 19);
         if (pick == 0)
            wait_for_results();
         else if (pick < 14)
            idle_gap($urandom_range(1, 6));
      end
   endtask

   // run the current sequence to idle, then let every result word come back
   task automatic settle();
      bit b;
      bit s;
      while (board.step != S_IDLE) begin
         pick_tick(b, s);
         send_tick(b, s);
      end
      wait_for_results();
   endtask

   task automatic program_regs(input logic [6:0] addr, input logic [7:0] mode,
                               input logic [23:0] start_ticks, input logic [23:0] conv_ticks);
      logic [CSR_DATA_W-1:0] addr_word;
      logic [CSR_DATA_W-1:0] mode_word;
      // unused upper bits carry noise, the register keeps only its own width
      addr_word = {17'($urandom), addr};
      mode_word = {16'($urandom), mode};
      csr_we    <= 1'b1;
      csr_index <= CSR_DEVICE_ADDRESS;
      csr_wdata <= addr_word;
      board.write_reg(CSR_DEVICE_ADDRESS, addr_word);
      @(posedge clock);
      csr_index <= CSR_MODE_COMMAND;
      csr_wdata <= mode_word;
      board.write_reg(CSR_MODE_COMMAND, mode_word);
      @(posedge clock);
      csr_index <= CSR_STARTUP_WAIT;
      csr_wdata <= start_ticks;
      board.write_reg(CSR_STARTUP_WAIT, start_ticks);
      @(posedge clock);
      csr_index <= CSR_CONVERSION_WAIT;
      csr_wdata <= conv_ticks;
      board.write_reg(CSR_CONVERSION_WAIT, conv_ticks);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      logic [2:0] ack;
      board = new();
      allow_begin = 1'b0;
      fail_plan = 3'd0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // idle ticks under the reset register values
      run_ticks(6);
      settle();

      // zero waits, begin held high all through, first acknowledge missing
      program_regs(7'd127, 8'd255, 24'd0, 24'd0);
      fail_plan = 3'd1;
      send_tick(1'b1, 1'b0);
      while (board.step != S_IDLE) begin
         ack = board.ack_under_test();
         send_tick(1'b1, (ack != 3'd0) ? (ack == fail_plan) : 1'($urandom_range(0, 1)));
      end
      wait_for_results();

      allow_begin = 1'b1;
      program_regs(7'd0, 8'd0, 24'd1, 24'd1);
      run_ticks(200);
      settle();

      for (int p = 0; p < 2; p++) begin
         program_regs(7'($urandom), 8'($urandom),
                      24'($urandom_range(0, 30)), 24'($urandom_range(0, 30)));
         run_ticks(80);
         settle();
      end

      // longest waits: far too long to sit through, so no sequence is begun
      allow_begin = 1'b0;
      program_regs(7'($urandom), 8'($urandom), 24'hFFFFFF, 24'hFFFFFF);
      run_ticks(20);
      settle();

      allow_begin = 1'b1;
      program_regs(RST_DEVICE_ADDRESS, RST_MODE_COMMAND, 24'd2, 24'd0);
      run_ticks(60);
      settle();

      repeat (8) @(posedge clock);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
